[src/ptw_pkg.sv]
// Shared types, codes and helpers for the four-level page-table walker.
`default_nettype none

package ptw_pkg;

    localparam int VA_W            = 48;
    localparam int PA_W            = 52;
    localparam int PTE_W           = 64;
    localparam int LVL_W           = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int PTE_PRESENT = 0;
    localparam int PTE_WRITE   = 1;
    localparam int PTE_USER    = 2;
    localparam int PTE_PWT     = 3;
    localparam int PTE_PCD     = 4;
    localparam int PTE_LARGE   = 7;
    localparam int PTE_NX      = 63;

    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_RESPONSE  = 1'b1;

    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_MISS  = 1'b1;

    localparam logic [LVL_W-1:0] LVL_PAGE = 3'd0;
    localparam logic [LVL_W-1:0] LVL_PT   = 3'd1;
    localparam logic [LVL_W-1:0] LVL_PD   = 3'd2;
    localparam logic [LVL_W-1:0] LVL_PDP  = 3'd3;
    localparam logic [LVL_W-1:0] LVL_TOP  = 3'd4;

    typedef enum logic [4:0] {
        WALK_IDLE = 5'b00001,
        WALK_L4   = 5'b00010,
        WALK_L3   = 5'b00100,
        WALK_L2   = 5'b01000,
        WALK_L1   = 5'b10000
    } walk_state_t;

    typedef struct packed {
        logic              command;
        logic              present;
        logic              page_size;
        logic [VA_W-1:0]   vaddr;
        logic [PTE_W-1:0]  pte;
    } ptw_item_t;

    typedef struct packed {
        logic              kind;
        logic [PA_W-1:0]   read_address;
        logic              status;
        logic [LVL_W-1:0]  stop_level;
        logic [PTE_W-1:0]  result_address;
        logic              read_only;
        logic              user;
        logic              uncached;
        logic              no_execute;
    } ptw_result_t;

    function automatic logic [PA_W-1:0] entry_address(
        input logic [PA_W-1:0]  table_base,
        input logic [VA_W-1:0]  va,
        input logic [LVL_W-1:0] level
    );
        logic [8:0] idx;
        unique case (level)
            LVL_TOP: idx = va[47:39];
            LVL_PDP: idx = va[38:30];
            LVL_PD:  idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return {table_base[PA_W-1:12], idx, 3'b000};
    endfunction

endpackage

`default_nettype wire

[src/ptw_front.sv]
// Front end: accepts input transfers, decodes them and queues them for the walker.
`default_nettype none

module ptw_front
    import ptw_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_command,
    input  wire logic [VA_W-1:0]   s_virtual_address,
    input  wire logic [PTE_W-1:0]  s_read_data,
    output logic                   q_valid,
    output ptw_item_t              q_item,
    input  wire logic              q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ptw_item_t             queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  push;
    ptw_item_t             item_in;

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign push    = s_valid && s_ready;
    assign q_item  = queue_mem[rd_ptr_reg];

    always_comb begin
        item_in.command   = s_command;
        item_in.present   = s_read_data[PTE_PRESENT];
        item_in.page_size = s_read_data[PTE_LARGE];
        item_in.vaddr     = s_virtual_address;
        item_in.pte       = s_read_data;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

[src/ptw_back.sv]
// Back end: walk state machine, root register and registered result stage.
`default_nettype none

module ptw_back
    import ptw_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [PA_W-1:0]  cfg_wr_data,
    input  wire logic             q_valid,
    input  wire ptw_item_t        q_item,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ptw_result_t           m_result
);

    logic [PA_W-1:0]   root_reg;
    walk_state_t       state_reg, state_next;
    logic [VA_W-1:0]   vaddr_reg, vaddr_next;
    logic [PTE_W-1:0]  prev_reg, prev_next;
    logic              out_valid_reg, out_valid_next;
    ptw_result_t       out_reg, out_next;
    logic              emit;
    logic [LVL_W-1:0]  cur_level;

    assign q_pop    = q_valid && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_comb begin
        unique case (state_reg)
            WALK_L4: cur_level = LVL_TOP;
            WALK_L3: cur_level = LVL_PDP;
            WALK_L2: cur_level = LVL_PD;
            WALK_L1: cur_level = LVL_PT;
            default: cur_level = LVL_PAGE;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        vaddr_next = vaddr_reg;
        prev_next  = prev_reg;
        emit       = 1'b0;
        out_next   = '0;
        if (q_pop) begin
            if (q_item.command == CMD_TRANSLATE) begin
                if (state_reg == WALK_IDLE) begin
                    emit                  = 1'b1;
                    state_next            = WALK_L4;
                    vaddr_next            = q_item.vaddr;
                    prev_next             = {{(PTE_W-PA_W){1'b0}}, root_reg};
                    out_next.kind         = KIND_READ;
                    out_next.read_address = entry_address(root_reg, q_item.vaddr, LVL_TOP);
                end
            end else if (state_reg != WALK_IDLE) begin
                emit = 1'b1;
                if (!q_item.present) begin
                    // missing entry: report level and last valid entry
                    state_next              = WALK_IDLE;
                    out_next.kind           = KIND_RESULT;
                    out_next.status         = STATUS_MISS;
                    out_next.stop_level     = cur_level;
                    out_next.result_address = prev_reg;
                end else if (state_reg == WALK_L1
                             || (state_reg == WALK_L2 && q_item.page_size)) begin
                    state_next          = WALK_IDLE;
                    out_next.kind       = KIND_RESULT;
                    out_next.status     = STATUS_FOUND;
                    out_next.stop_level = LVL_PAGE;
                    if (state_reg == WALK_L2) begin
                        out_next.result_address = {{(PTE_W-PA_W){1'b0}},
                                                   q_item.pte[PA_W-1:21], vaddr_reg[20:0]};
                    end else begin
                        out_next.result_address = {{(PTE_W-PA_W){1'b0}},
                                                   q_item.pte[PA_W-1:12], vaddr_reg[11:0]};
                    end
                    out_next.read_only  = ~q_item.pte[PTE_WRITE];
                    out_next.user       = q_item.pte[PTE_USER];
                    out_next.uncached   = q_item.pte[PTE_PCD] & q_item.pte[PTE_PWT]
                                          & ~q_item.pte[PTE_LARGE];
                    out_next.no_execute = q_item.pte[PTE_NX];
                end else begin
                    // descend one level
                    prev_next     = q_item.pte;
                    out_next.kind = KIND_READ;
                    out_next.read_address = entry_address(q_item.pte[PA_W-1:0], vaddr_reg,
                                                          cur_level - 1'b1);
                    unique case (state_reg)
                        WALK_L4: state_next = WALK_L3;
                        WALK_L3: state_next = WALK_L2;
                        WALK_L2: state_next = WALK_L1;
                        default: state_next = WALK_IDLE;
                    endcase
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (q_pop) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg      <= '0;
            state_reg     <= WALK_IDLE;
            vaddr_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                root_reg <= cfg_wr_data;
            end
            state_reg     <= state_next;
            vaddr_reg     <= vaddr_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && emit) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

[src/four_level_page_table_walker_top.sv]
// Top level of the four-level page-table walker.
//
// Input channel (s_*): each transfer is either a translate request
// (s_command = 0, s_virtual_address) or a memory read response carrying one
// 64-bit table entry (s_command = 1, s_read_data). Translate requests that
// arrive during a walk and responses that arrive while idle are dropped.
// Result channel (m_*): a memory read request (m_kind = 0, m_read_address)
// or a translation result (m_kind = 1, status, level, address, flags).
// cfg_wr_en/cfg_wr_data load the root table address; write it only while
// no walk is in progress.
// A transfer is written into the input queue and then moved into the output
// register once that register is empty or being read; m_valid comes from it.
// Throughput: one input transfer per cycle while the queue is not full; the
// walk state machine handles one table level per item.
// Reset empties the queue, clears m_valid, the root register and the
// walk state. When the receiver stalls, the output register holds and the
// input queue (QUEUE_DEPTH entries) absorbs transfers until it fills.
`default_nettype none

module four_level_page_table_walker_top
    import ptw_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [PA_W-1:0]   cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_command,
    input  wire logic [VA_W-1:0]   s_virtual_address,
    input  wire logic [PTE_W-1:0]  s_read_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_kind,
    output logic [PA_W-1:0]        m_read_address,
    output logic                   m_status,
    output logic [LVL_W-1:0]       m_stop_level,
    output logic [PTE_W-1:0]       m_result_address,
    output logic                   m_read_only,
    output logic                   m_user,
    output logic                   m_uncached,
    output logic                   m_no_execute
);

    logic        q_valid;
    logic        q_pop;
    ptw_item_t   q_item;
    ptw_result_t m_result;

    ptw_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_virtual_address (s_virtual_address),
        .s_read_data       (s_read_data),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop)
    );

    ptw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

    assign m_kind           = m_result.kind;
    assign m_read_address   = m_result.read_address;
    assign m_status         = m_result.status;
    assign m_stop_level     = m_result.stop_level;
    assign m_result_address = m_result.result_address;
    assign m_read_only      = m_result.read_only;
    assign m_user           = m_result.user;
    assign m_uncached       = m_result.uncached;
    assign m_no_execute     = m_result.no_execute;

endmodule

`default_nettype wire

[src/ptw_checker.sv]
// Port-level assertions for the page-table walker, bound to the top level.
`default_nettype none

module ptw_checker
    import ptw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic              m_kind,
    input  wire logic [PA_W-1:0]   m_read_address,
    input  wire logic              m_status,
    input  wire logic [LVL_W-1:0]  m_stop_level,
    input  wire logic [PTE_W-1:0]  m_result_address,
    input  wire logic              m_read_only,
    input  wire logic              m_user,
    input  wire logic              m_uncached,
    input  wire logic              m_no_execute
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_read_address)
            && $stable(m_result_address) && $stable(m_status))
        else $error("result changed while stalled");

    a_read_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_READ |-> m_status == STATUS_FOUND
            && m_stop_level == LVL_PAGE && m_result_address == '0
            && !m_read_only && !m_user && !m_uncached && !m_no_execute
            && m_read_address[2:0] == 3'b000)
        else $error("malformed read request");

    a_miss_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_RESULT && m_status == STATUS_MISS |->
            m_read_address == '0 && !m_read_only && !m_user && !m_uncached
            && !m_no_execute && (m_stop_level == LVL_PT || m_stop_level == LVL_PD
            || m_stop_level == LVL_PDP || m_stop_level == LVL_TOP))
        else $error("malformed not-found result");

    a_found_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_RESULT && m_status == STATUS_FOUND |->
            m_stop_level == LVL_PAGE && m_read_address == '0
            && m_result_address[PTE_W-1:PA_W] == '0)
        else $error("malformed found result");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind four_level_page_table_walker_top ptw_checker u_ptw_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_kind           (m_kind),
    .m_read_address   (m_read_address),
    .m_status         (m_status),
    .m_stop_level     (m_stop_level),
    .m_result_address (m_result_address),
    .m_read_only      (m_read_only),
    .m_user           (m_user),
    .m_uncached       (m_uncached),
    .m_no_execute     (m_no_execute)
);

`default_nettype wire

[tb/sv/four_level_page_table_walker_top_test.sv]
// Self-checking testbench for the four-level page-table walker top level.
`default_nettype none

module four_level_page_table_walker_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptw_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;

    class walk_scoreboard;
        logic [PA_W-1:0]  root;
        bit               busy;
        logic [LVL_W-1:0] level;
        logic [VA_W-1:0]  walk_va;
        logic [PTE_W-1:0] last_entry;
        ptw_result_t      due_outputs[$];
        int               errors;
        int               outputs_predicted;

        function new();
            root = '0;
            busy = 1'b0;
            level = LVL_TOP;
            walk_va = '0;
            last_entry = '0;
            errors = 0;
            outputs_predicted = 0;
        endfunction

        function logic [PA_W-1:0] walk_slot(logic [PA_W-1:0] frame_src, logic [LVL_W-1:0] lvl);
            int shift;
            logic [PA_W-1:0] slot;
            shift = 12 + 9 * (int'(lvl) - 1);
            slot = '0;
            slot[11:3] = walk_va[shift +: 9];
            return {frame_src[PA_W-1:12], 12'h000} | slot;
        endfunction

        // Note one accepted transfer and queue the output it causes.
        function void walk_step(logic cmd, logic [VA_W-1:0] va, logic [PTE_W-1:0] pte);
            ptw_result_t r;
            r = '0;
            if (cmd == CMD_TRANSLATE) begin
                if (busy) return;
                busy = 1'b1;
                level = LVL_TOP;
                walk_va = va;
                last_entry = {{(PTE_W-PA_W){1'b0}}, root};
                r.kind = KIND_READ;
                r.read_address = walk_slot(root, LVL_TOP);
            end else begin
                if (!busy) return;
                if (!pte[PTE_PRESENT]) begin
                    r.kind = KIND_RESULT;
                    r.status = STATUS_MISS;
                    r.stop_level = level;
                    r.result_address = last_entry;
                    busy = 1'b0;
                    level = LVL_TOP;
                end else if (level == LVL_PT || (level == LVL_PD && pte[PTE_LARGE])) begin
                    r.kind = KIND_RESULT;
                    r.status = STATUS_FOUND;
                    r.stop_level = LVL_PAGE;
                    if (level == LVL_PD)
                        r.result_address = {12'h000, pte[PA_W-1:21], walk_va[20:0]};
                    else
                        r.result_address = {12'h000, pte[PA_W-1:12], walk_va[11:0]};
                    r.read_only = !pte[PTE_WRITE];
                    r.user = pte[PTE_USER];
                    r.uncached = pte[PTE_PCD] & pte[PTE_PWT] & !pte[PTE_LARGE];
                    r.no_execute = pte[PTE_NX];
                    busy = 1'b0;
                    level = LVL_TOP;
                end else begin
                    last_entry = pte;
                    level = level - 1'b1;
                    r.kind = KIND_READ;
                    r.read_address = walk_slot(pte[PA_W-1:0], level);
                end
            end
            due_outputs.push_back(r);
            outputs_predicted++;
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("%0t: %s got %h, expected %h", $realtime, what, got, want);
        endtask

        task check_result(ptw_result_t got);
            ptw_result_t want;
            if (due_outputs.size() == 0) begin
                report_mismatch("output with none due, result_address", got.result_address, '0);
                return;
            end
            want = due_outputs.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", 64'(got.kind), 64'(want.kind));
            if (got.read_address !== want.read_address)
                report_mismatch("read_address", 64'(got.read_address), 64'(want.read_address));
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.stop_level !== want.stop_level)
                report_mismatch("stop_level", 64'(got.stop_level), 64'(want.stop_level));
            if (got.result_address !== want.result_address)
                report_mismatch("result_address", got.result_address, want.result_address);
            if (got.read_only !== want.read_only)
                report_mismatch("read_only", 64'(got.read_only), 64'(want.read_only));
            if (got.user !== want.user)
                report_mismatch("user", 64'(got.user), 64'(want.user));
            if (got.uncached !== want.uncached)
                report_mismatch("uncached", 64'(got.uncached), 64'(want.uncached));
            if (got.no_execute !== want.no_execute)
                report_mismatch("no_execute", 64'(got.no_execute), 64'(want.no_execute));
        endtask
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [PA_W-1:0]   cfg_wr_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_command;
    logic [VA_W-1:0]   s_virtual_address;
    logic [PTE_W-1:0]  s_read_data;
    logic              m_valid;
    logic              m_ready;
    logic              m_kind;
    logic [PA_W-1:0]   m_read_address;
    logic              m_status;
    logic [LVL_W-1:0]  m_stop_level;
    logic [PTE_W-1:0]  m_result_address;
    logic              m_read_only;
    logic              m_user;
    logic              m_uncached;
    logic              m_no_execute;

    walk_scoreboard sb;
    ptw_result_t    seen_output;
    bit             idle_on = 1'b1;
    bit             hold_request = 1'b0;
    int             cycle_count = 0;

    four_level_page_table_walker_top DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_virtual_address (s_virtual_address),
        .s_read_data       (s_read_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_read_address    (m_read_address),
        .m_status          (m_status),
        .m_stop_level      (m_stop_level),
        .m_result_address  (m_result_address),
        .m_read_only       (m_read_only),
        .m_user            (m_user),
        .m_uncached        (m_uncached),
        .m_no_execute      (m_no_execute)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("four_level_page_table_walker_top: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid && m_ready) begin
            seen_output.kind = m_kind;
            seen_output.read_address = m_read_address;
            seen_output.status = m_status;
            seen_output.stop_level = m_stop_level;
            seen_output.result_address = m_result_address;
            seen_output.read_only = m_read_only;
            seen_output.user = m_user;
            seen_output.uncached = m_uncached;
            seen_output.no_execute = m_no_execute;
            sb.check_result(seen_output);
        end
    end

    // Receiver: random stalls, one long hold on request.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    function automatic logic [VA_W-1:0] pick_va();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) return '1;
        if (sel == 1) return '0;
        return VA_W'({$urandom, $urandom});
    endfunction

    function automatic logic [PTE_W-1:0] pick_entry();
        int sel;
        logic [PTE_W-1:0] pte;
        sel = $urandom_range(0, 15);
        if (sel == 0) pte = '1;
        else if (sel == 1) pte = '0;
        else pte = {$urandom, $urandom};
        pte[PTE_PRESENT] = ($urandom_range(0, 99) < 85);
        return pte;
    endfunction

    // Hold the item until the transfer, then note it.
    task automatic offer(logic cmd, logic [VA_W-1:0] va, logic [PTE_W-1:0] pte);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_virtual_address <= va;
        s_read_data <= pte;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.walk_step(cmd, va, pte);
    endtask

    task automatic pause(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.due_outputs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_root(logic [PA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.root = value;
    endtask

    task automatic finish_walk();
        while (sb.busy) offer(CMD_RESPONSE, pick_va(), pick_entry());
    endtask

    task automatic random_walks(int target, bit with_hold);
        int done;
        int prev_count;
        bit hold_sent;
        done = 0;
        hold_sent = 1'b0;
        while (done < target) begin
            if (with_hold && !hold_sent && done >= 40) begin
                hold_request = 1'b1;
                hold_sent = 1'b1;
            end
            prev_count = sb.outputs_predicted;
            if ((!sb.busy && $urandom_range(0, 19) != 0) || (sb.busy && $urandom_range(0, 11) == 0))
                offer(CMD_TRANSLATE, pick_va(), pick_entry());
            else
                offer(CMD_RESPONSE, pick_va(), pick_entry());
            if (sb.outputs_predicted != prev_count)
                done++;
            if (idle_on && (done % 100) < 60 && $urandom_range(0, 5) == 0)
                pause($urandom_range(1, 15));
        end
    endtask

    initial begin
        logic [PA_W-1:0] roots[5];
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_valid <= 1'b0;
        s_command <= CMD_TRANSLATE;
        s_virtual_address <= '0;
        s_read_data <= '0;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_root('1);
        offer(CMD_RESPONSE, '0, '1);
        offer(CMD_TRANSLATE, '1, '0);
        offer(CMD_TRANSLATE, '0, '0);
        offer(CMD_RESPONSE, '0, '1);
        offer(CMD_RESPONSE, '0, 64'h000A_BCDE_F012_3081);
        offer(CMD_RESPONSE, '0, '1);
        offer(CMD_TRANSLATE, '0, '1);
        offer(CMD_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFE);
        offer(CMD_TRANSLATE, 48'h8040_2010_0FFF, '0);
        offer(CMD_RESPONSE, '0, 64'h8000_0000_1234_5007);
        offer(CMD_RESPONSE, '0, '0);
        offer(CMD_TRANSLATE, 48'h0000_7FFF_F000, '0);
        offer(CMD_RESPONSE, '0, 64'h0000_0000_0000_0001);
        offer(CMD_RESPONSE, '0, 64'h0000_0000_0000_0003);
        offer(CMD_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFE);
        offer(CMD_TRANSLATE, 48'h1234_5678_9ABC, '0);
        offer(CMD_RESPONSE, '0, 64'h0000_0000_0000_0001);
        offer(CMD_RESPONSE, '0, 64'h0000_0000_0000_0001);
        offer(CMD_RESPONSE, '0, 64'h0000_0000_0000_0001);
        offer(CMD_RESPONSE, '0, 64'h7FFF_FFFF_FFFF_FF7E);
        offer(CMD_TRANSLATE, '1, '0);
        offer(CMD_RESPONSE, '0, 64'h0000_0000_0000_0003);
        offer(CMD_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FF7F);
        offer(CMD_RESPONSE, '0, 64'h000F_FFFF_FFFF_F07F);
        offer(CMD_RESPONSE, '0, 64'h000F_FFFF_FFFF_F019);
        offer(CMD_TRANSLATE, 48'hFFFF_FFFF_F000, '0);
        offer(CMD_RESPONSE, '0, 64'h0000_0000_0000_0001);
        offer(CMD_RESPONSE, '0, 64'h0000_0000_0000_0001);
        offer(CMD_RESPONSE, '0, 64'h0000_0000_0000_0001);
        offer(CMD_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFF);
        settle();

        roots[0] = '0;
        roots[1] = PA_W'({$urandom, $urandom});
        roots[2] = PA_W'({$urandom, $urandom}) | 52'hFFF;
        roots[3] = 52'h0_0000_0000_1000;
        roots[4] = '1;
        for (int ph = 0; ph < 5; ph++) begin
            idle_on = (ph < 4);
            load_root(roots[ph]);
            random_walks(250, ph == 2);
            finish_walk();
            settle();
        end

        if (sb.errors == 0 && sb.due_outputs.size() == 0)
            $display("four_level_page_table_walker_top: match");
        else
            $display("four_level_page_table_walker_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
